### design/nafa_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nafa_pkg
// Shared types and constants for the n-dimensional axis flip addresser.
// ----------------------------------------------------------------------------
package nafa_pkg;

    localparam int NUM_DIMS    = 4;
    localparam int COORD_W     = 16;
    localparam int EXT_W       = 17;
    localparam int OFFSET_W    = 16;
    localparam int VALUE_W     = 32;
    localparam int ADDR_W      = 5;
    localparam int DATA_W      = 32;
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = 1;
    localparam int QCNT_W      = 2;

    localparam logic [2:0] REG_DIM_COUNT = 3'd0;
    localparam logic [2:0] REG_FLIP_AXIS = 3'd1;
    localparam logic [2:0] REG_EXTENT0   = 3'd2;
    localparam logic [2:0] REG_EXTENT1   = 3'd3;
    localparam logic [2:0] REG_EXTENT2   = 3'd4;
    localparam logic [2:0] REG_EXTENT3   = 3'd5;

    typedef struct packed {
        logic [2:0]                             dims;
        logic [2:0]                             flip_axis;
        logic [NUM_DIMS-1:0][EXT_W-1:0]         ext;
        logic [NUM_DIMS-1:0][OFFSET_W-1:0]      stride;
        logic                                   busy;
        logic                                   restart;
    } nafa_ctrl_t;

    typedef struct packed {
        logic [NUM_DIMS-1:0][COORD_W-1:0]       coord;
        logic [VALUE_W-1:0]                     value;
        logic                                   last;
        logic                                   err;
    } nafa_entry_t;

endpackage

### design/nafa_in_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nafa_in_if
// Element request channel: valid, ready and one source element value.
// ----------------------------------------------------------------------------
interface nafa_in_if import nafa_pkg::*; ();

    logic               valid;
    logic               ready;
    logic [VALUE_W-1:0] element_value;

    modport source (output valid, output element_value, input ready);
    modport sink   (input valid, input element_value, output ready);

endinterface

### design/nafa_out_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nafa_out_if
// Result request channel: destination offset, value, last mark, axis error.
// ----------------------------------------------------------------------------
interface nafa_out_if import nafa_pkg::*; ();

    logic                valid;
    logic                ready;
    logic [OFFSET_W-1:0] dest_offset;
    logic [VALUE_W-1:0]  moved_value;
    logic                last_element;
    logic                axis_error;

    modport source (output valid, output dest_offset, output moved_value,
                    output last_element, output axis_error, input ready);
    modport sink   (input valid, input dest_offset, input moved_value,
                    input last_element, input axis_error, output ready);

endinterface

### design/nafa_cfg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nafa_cfg
// Register file on the apb port, effective shape and stride products.
// ----------------------------------------------------------------------------
module nafa_cfg import nafa_pkg::*; (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready,
    output nafa_ctrl_t        ctrl
);

    function automatic logic [2:0] dims_in_use(input logic [2:0] raw);
        logic [2:0] n;
        n = raw;
        if (n == 3'd0)
            n = 3'd1;
        if (n > 3'(NUM_DIMS))
            n = 3'(NUM_DIMS);
        return n;
    endfunction

    function automatic logic [EXT_W-1:0] sat_extent(input logic [EXT_W-1:0] raw);
        logic [EXT_W-1:0] e;
        e = raw;
        if (e == '0)
            e = EXT_W'(1);
        if (e > EXT_W'(65536))
            e = EXT_W'(65536);
        return e;
    endfunction

    logic [2:0]       dim_count_reg, dim_count_next;
    logic [2:0]       flip_axis_reg, flip_axis_next;
    logic [EXT_W-1:0] extent_reg [NUM_DIMS];
    logic [EXT_W-1:0] extent_next [NUM_DIMS];
    logic [OFFSET_W-1:0] pair_reg, pair_next;
    logic [OFFSET_W-1:0] outer_reg, outer_next;
    logic [1:0]       busy_reg, busy_next;
    logic             restart;
    logic             wr_en;
    logic [2:0]       wr_idx;
    logic [2:0]       dims;
    logic [EXT_W-1:0] ext_eff [NUM_DIMS];
    logic [2*OFFSET_W-1:0] pair_full;
    logic [2*OFFSET_W-1:0] outer_full;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;
    assign wr_idx = paddr[4:2];

    always_comb
    begin
        dim_count_next = dim_count_reg;
        flip_axis_next = flip_axis_reg;
        for (int d = 0; d < NUM_DIMS; d++)
        begin
            extent_next[d] = extent_reg[d];
        end
        restart = 1'b0;
        if (wr_en)
        begin
            case (wr_idx)
                REG_DIM_COUNT:
                begin
                    dim_count_next = pwdata[2:0];
                    restart = 1'b1;
                end
                REG_FLIP_AXIS:
                begin
                    flip_axis_next = pwdata[2:0];
                    restart = 1'b1;
                end
                REG_EXTENT0:
                begin
                    extent_next[0] = pwdata[EXT_W-1:0];
                    restart = 1'b1;
                end
                REG_EXTENT1:
                begin
                    extent_next[1] = pwdata[EXT_W-1:0];
                    restart = 1'b1;
                end
                REG_EXTENT2:
                begin
                    extent_next[2] = pwdata[EXT_W-1:0];
                    restart = 1'b1;
                end
                REG_EXTENT3:
                begin
                    extent_next[3] = pwdata[EXT_W-1:0];
                    restart = 1'b1;
                end
                default:
                begin
                    restart = 1'b0;
                end
            endcase
        end
    end

    always_comb
    begin
        case (wr_idx)
            REG_DIM_COUNT: prdata = {29'd0, dim_count_reg};
            REG_FLIP_AXIS: prdata = {29'd0, flip_axis_reg};
            REG_EXTENT0:   prdata = {15'd0, extent_reg[0]};
            REG_EXTENT1:   prdata = {15'd0, extent_reg[1]};
            REG_EXTENT2:   prdata = {15'd0, extent_reg[2]};
            REG_EXTENT3:   prdata = {15'd0, extent_reg[3]};
            default:       prdata = '0;
        endcase
    end

    // effective shape, dims past the count have extent one
    assign dims = dims_in_use(dim_count_reg);

    always_comb
    begin
        for (int d = 0; d < NUM_DIMS; d++)
        begin
            if (d < int'(dims))
                ext_eff[d] = sat_extent(extent_reg[d]);
            else
                ext_eff[d] = EXT_W'(1);
        end
    end

    // stride products modulo the offset width
    assign pair_full  = (2*OFFSET_W)'(ext_eff[3][OFFSET_W-1:0])
                      * (2*OFFSET_W)'(ext_eff[2][OFFSET_W-1:0]);
    assign outer_full = (2*OFFSET_W)'(pair_reg) * (2*OFFSET_W)'(ext_eff[1][OFFSET_W-1:0]);
    assign pair_next  = pair_full[OFFSET_W-1:0];
    assign outer_next = outer_full[OFFSET_W-1:0];

    always_comb
    begin
        busy_next = busy_reg;
        if (wr_en)
            busy_next = 2'd2;
        else if (busy_reg != 2'd0)
            busy_next = busy_reg - 2'd1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dim_count_reg <= 3'd1;
            flip_axis_reg <= 3'd0;
            for (int d = 0; d < NUM_DIMS; d++)
            begin
                extent_reg[d] <= EXT_W'(1);
            end
            pair_reg  <= OFFSET_W'(1);
            outer_reg <= OFFSET_W'(1);
            busy_reg  <= 2'd0;
        end
        else
        begin
            dim_count_reg <= dim_count_next;
            flip_axis_reg <= flip_axis_next;
            for (int d = 0; d < NUM_DIMS; d++)
            begin
                extent_reg[d] <= extent_next[d];
            end
            pair_reg  <= pair_next;
            outer_reg <= outer_next;
            busy_reg  <= busy_next;
        end
    end

    always_comb
    begin
        ctrl.dims      = dims;
        ctrl.flip_axis = flip_axis_reg;
        for (int d = 0; d < NUM_DIMS; d++)
        begin
            ctrl.ext[d] = ext_eff[d];
        end
        ctrl.stride[3] = OFFSET_W'(1);
        ctrl.stride[2] = ext_eff[3][OFFSET_W-1:0];
        ctrl.stride[1] = pair_reg;
        ctrl.stride[0] = outer_reg;
        ctrl.busy      = (busy_reg != 2'd0);
        ctrl.restart   = restart;
    end

    a_write_sets_busy: assert property (@(posedge clk) disable iff (!rst_n)
        wr_en |=> ctrl.busy)
        else $error("config write did not hold off requests");

endmodule

### design/nafa_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nafa_front
// Coordinate counter: accepts elements, mirrors the flip axis, marks the last.
// ----------------------------------------------------------------------------
module nafa_front import nafa_pkg::*; (
    input  logic        clk,
    input  logic        rst_n,
    input  nafa_ctrl_t  ctrl,
    nafa_in_if.sink     elem,
    input  logic        queue_full,
    output logic        push,
    output nafa_entry_t push_data
);

    logic [COORD_W-1:0] coord_reg [NUM_DIMS];
    logic [COORD_W-1:0] coord_next [NUM_DIMS];
    logic [COORD_W-1:0] coord_step [NUM_DIMS];
    logic [EXT_W-1:0]   mirror [NUM_DIMS];
    logic [NUM_DIMS-1:0] wrap;
    logic               carry;
    logic               last;
    logic signed [3:0]  axis_norm;
    logic [1:0]         axis_idx;
    logic               err;

    assign elem.ready = !ctrl.busy && !queue_full;
    assign push       = elem.valid && elem.ready;

    // negative axis counts back from the dim count
    assign axis_norm = {ctrl.flip_axis[2], ctrl.flip_axis}
                     + (ctrl.flip_axis[2] ? $signed({1'b0, ctrl.dims}) : 4'sd0);
    assign err       = axis_norm[3] || (axis_norm[2:0] >= ctrl.dims);
    assign axis_idx  = axis_norm[1:0];

    always_comb
    begin
        carry = 1'b1;
        last  = 1'b1;
        for (int d = NUM_DIMS - 1; d >= 0; d--)
        begin
            wrap[d]   = (({1'b0, coord_reg[d]} + EXT_W'(1)) >= ctrl.ext[d]);
            mirror[d] = ctrl.ext[d] - EXT_W'(1) - {1'b0, coord_reg[d]};
            if (d < int'(ctrl.dims))
            begin
                last = last & wrap[d];
                if (carry)
                    coord_step[d] = wrap[d] ? '0 : coord_reg[d] + COORD_W'(1);
                else
                    coord_step[d] = coord_reg[d];
                carry = carry & wrap[d];
            end
            else
            begin
                coord_step[d] = '0;
            end
        end
    end

    always_comb
    begin
        for (int d = 0; d < NUM_DIMS; d++)
        begin
            if (ctrl.restart)
                coord_next[d] = '0;
            else if (push)
                coord_next[d] = coord_step[d];
            else
                coord_next[d] = coord_reg[d];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int d = 0; d < NUM_DIMS; d++)
            begin
                coord_reg[d] <= '0;
            end
        end
        else
        begin
            for (int d = 0; d < NUM_DIMS; d++)
            begin
                coord_reg[d] <= coord_next[d];
            end
        end
    end

    // error zeroes every coordinate so the offset comes out zero
    always_comb
    begin
        for (int d = 0; d < NUM_DIMS; d++)
        begin
            if (err)
                push_data.coord[d] = '0;
            else if (2'(d) == axis_idx)
                push_data.coord[d] = mirror[d][COORD_W-1:0];
            else
                push_data.coord[d] = coord_reg[d];
        end
        push_data.value = elem.element_value;
        push_data.last  = last;
        push_data.err   = err;
    end

    a_busy_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.busy |-> !elem.ready)
        else $error("request taken while strides settle");

    a_restart_clears: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.restart |=> (coord_reg[0] == '0 && coord_reg[1] == '0
                          && coord_reg[2] == '0 && coord_reg[3] == '0))
        else $error("coordinates not cleared after config write");

endmodule

### design/nafa_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nafa_queue
// Short fifo between the coordinate front end and the offset back end.
// ----------------------------------------------------------------------------
module nafa_queue import nafa_pkg::*; (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    input  nafa_entry_t push_data,
    output logic        full,
    input  logic        pop,
    output nafa_entry_t pop_data,
    output logic        empty
);

    nafa_entry_t       entry_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] count_reg, count_next;

    assign full     = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign empty    = (count_reg == '0);
    assign pop_data = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + QPTR_W'(1) : wr_ptr_reg;
        rd_ptr_next = pop  ? rd_ptr_reg + QPTR_W'(1) : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
            count_next = count_reg + QCNT_W'(1);
        else if (pop && !push)
            count_next = count_reg - QCNT_W'(1);
    end

    always_ff @(posedge clk)
    begin
        if (push)
            entry_reg[wr_ptr_reg] <= push_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
        (push && full) |-> pop)
        else $error("queue overrun");

endmodule

### design/nafa_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nafa_back
// Offset back end: coordinate times stride, sum, registered result.
// ----------------------------------------------------------------------------
module nafa_back import nafa_pkg::*; (
    input  logic        clk,
    input  logic        rst_n,
    input  nafa_ctrl_t  ctrl,
    input  nafa_entry_t head,
    input  logic        empty,
    output logic        pop,
    nafa_out_if.source  result
);

    logic                s1_valid_reg, s1_valid_next;
    logic [OFFSET_W-1:0] s1_prod_reg [NUM_DIMS];
    logic [VALUE_W-1:0]  s1_value_reg;
    logic                s1_last_reg;
    logic                s1_err_reg;
    logic                out_valid_reg, out_valid_next;
    logic [OFFSET_W-1:0] out_offset_reg;
    logic [VALUE_W-1:0]  out_value_reg;
    logic                out_last_reg;
    logic                out_err_reg;
    logic [2*OFFSET_W-1:0] prod_full [NUM_DIMS];
    logic [OFFSET_W-1:0] offset_sum;
    logic                out_ready;
    logic                s1_ready;
    logic                s1_move;

    assign out_ready = !out_valid_reg || result.ready;
    assign s1_ready  = !s1_valid_reg || out_ready;
    assign pop       = !empty && s1_ready;
    assign s1_move   = s1_valid_reg && out_ready;

    always_comb
    begin
        for (int d = 0; d < NUM_DIMS; d++)
        begin
            prod_full[d] = (2*OFFSET_W)'(head.coord[d]) * (2*OFFSET_W)'(ctrl.stride[d]);
        end
    end

    assign offset_sum = s1_prod_reg[0] + s1_prod_reg[1] + s1_prod_reg[2] + s1_prod_reg[3];

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (s1_ready)
            s1_valid_next = pop;
        out_valid_next = out_valid_reg;
        if (out_ready)
            out_valid_next = s1_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            for (int d = 0; d < NUM_DIMS; d++)
            begin
                s1_prod_reg[d] <= prod_full[d][OFFSET_W-1:0];
            end
            s1_value_reg <= head.value;
            s1_last_reg  <= head.last;
            s1_err_reg   <= head.err;
        end
        if (s1_move)
        begin
            out_offset_reg <= offset_sum;
            out_value_reg  <= s1_value_reg;
            out_last_reg   <= s1_last_reg;
            out_err_reg    <= s1_err_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign result.valid        = out_valid_reg;
    assign result.dest_offset  = out_offset_reg;
    assign result.moved_value  = out_value_reg;
    assign result.last_element = out_last_reg;
    assign result.axis_error   = out_err_reg;

    a_error_zero_offset: assert property (@(posedge clk) disable iff (!rst_n)
        (result.valid && result.axis_error) |-> (result.dest_offset == '0))
        else $error("offset not zero on axis error");

endmodule

### design/nd_array_axis_flip_addresser_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nd_array_axis_flip_addresser_top
// Axis flip addresser: row-major element stream in, mirrored offsets out.
// ----------------------------------------------------------------------------
// Takes one element per cycle in row-major order, while no configuration
// write is settling and the queue has room, and returns one result per cycle
// while the result channel is ready: the destination offset with the flip
// axis mirrored, the value, a last mark and an axis error flag. The coordinate
// counter in the front end steps once per accepted element. The queue entry is
// written when a request is taken, then come the stride multiply stage and the
// output register. After every configuration write the element ready drops
// while the two-stage stride multiplier recomputes, and a write to a defined
// register restarts the coordinate counter at zero.
module nd_array_axis_flip_addresser_top import nafa_pkg::*; (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready,
    nafa_in_if.sink           elem,
    nafa_out_if.source        result
);

    nafa_ctrl_t  ctrl;
    logic        push;
    logic        pop;
    logic        full;
    logic        empty;
    nafa_entry_t push_data;
    nafa_entry_t pop_data;

    nafa_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .ctrl    (ctrl)
    );

    nafa_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctrl       (ctrl),
        .elem       (elem),
        .queue_full (full),
        .push       (push),
        .push_data  (push_data)
    );

    nafa_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .full      (full),
        .pop       (pop),
        .pop_data  (pop_data),
        .empty     (empty)
    );

    nafa_back u_back (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctrl   (ctrl),
        .head   (pop_data),
        .empty  (empty),
        .pop    (pop),
        .result (result)
    );

endmodule
